// ===== sv/arb_pkg.sv =====
// ----------------------------------------------------------------------------
// arb_pkg: shared types and constants of the audio ring buffer
// Item layouts, operation codes, sequencer states and shared-unit operations.
// ----------------------------------------------------------------------------
package arb_pkg;

  localparam int OP_W    = 2;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 13;
  localparam int FREE_W  = 13;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  data_in;
    logic [COUNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               underflow;
    logic [COUNT_W-1:0] delivered;
    logic [FREE_W-1:0]  free_space;
    logic               last;
  } out_item_t;

  typedef logic [CFG_W-1:0] cfg_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WINC,
    S_OCC,
    S_WRAP,
    S_CMP,
    S_FREE,
    S_RD,
    S_LOAD
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== sv/arb_chan_if.sv =====
// ----------------------------------------------------------------------------
// arb_chan_if: valid/ready channel
// Carries one item of type T per handshake between a source and a sink.
// ----------------------------------------------------------------------------
interface arb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/arb_ram.sv =====
// ----------------------------------------------------------------------------
// arb_ram: generic single-write, single-read memory
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module arb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/arb_alu.sv =====
// ----------------------------------------------------------------------------
// arb_alu: shared add/subtract unit
// Serves every pointer, occupancy and free-space step of the sequencer.
// ----------------------------------------------------------------------------
module arb_alu #(
  parameter int W = 14
) (
  input  arb_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     sum,
  output logic             neg
);
  import arb_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: sum = a + b;
      ALU_SUB: sum = a - b;
      default: sum = a + b;
    endcase
  end

  // Operands stay below the top bit, so it serves as the borrow.
  assign neg = sum[W-1];
endmodule

// ===== sv/audio_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// audio_ring_buffer_unit: circular byte store for audio
// Writes, flushes and burst reads over a byte memory with wrapping pointers.
//
//   Channel  Role    Item
//   in_ch    sink    op, data_in, count
//   out_ch   source  data_out, underflow, delivered, free_space, last
//   cfg_ch   sink    buffer_size
//
// A write stores its byte when accepted and steps the write pointer in S_WINC;
// a flush clears both pointers when accepted. A read burst runs its occupancy
// arithmetic on the shared adder in S_OCC, S_WRAP if the difference is
// negative, S_CMP and, without underflow, S_FREE; then each byte takes S_RD
// for the memory read and pointer step and S_LOAD to load the output register.
// A stalled output holds the sequencer in its load step. Reset clears the pointers,
// sets size to min(DEPTH, 4096) and leaves the memory contents undefined.
// ----------------------------------------------------------------------------
module audio_ring_buffer_unit #(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  arb_chan_if.sink   in_ch,
  arb_chan_if.source out_ch,
  arb_chan_if.sink   cfg_ch
);
  import arb_pkg::*;

  localparam int PW       = $clog2(DEPTH);
  localparam int SW       = $clog2(DEPTH + 1);
  localparam int DW       = (SW > COUNT_W) ? SW : COUNT_W;
  localparam int AW       = DW + 1;
  localparam int RST_SIZE = (DEPTH < 4096) ? DEPTH : 4096;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      wp_r, wp_nxt;
  logic [PW-1:0]      rp_r, rp_nxt;
  logic [SW-1:0]      size_r, size_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0]      addr_r, addr_nxt;
  logic [DW-1:0]      diff_r, diff_nxt;
  logic [SW-1:0]      free_r, free_nxt;
  logic               under_r, under_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  in_item_t           in_item;
  logic [CFG_W-1:0]   cfg_val;
  logic [COUNT_W-1:0] cnt_clamp;
  logic               in_fire, cfg_fire, load_ok;
  alu_op_t            alu_op;
  logic [AW-1:0]      alu_a, alu_b, alu_sum;
  logic               alu_neg;
  logic               ram_we, ram_re;
  logic [DATA_W-1:0]  ram_rdata;

  assign in_item   = in_ch.data;
  assign cfg_val   = cfg_ch.data;
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_fire  = cfg_ch.valid && cfg_ch.ready;
  assign load_ok   = (state_r == S_LOAD) && (!out_valid_r || out_ch.ready);
  assign cnt_clamp = (32'(in_item.count) > MAX_BURST) ? COUNT_W'(MAX_BURST)
                                                      : in_item.count;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  arb_alu #(.W(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  arb_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_item.data_in),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_item.op == OP_WRITE) begin
            state_nxt = S_WINC;
          end else if (in_item.op == OP_READ && in_item.count != '0) begin
            state_nxt = S_OCC;
          end
        end
      end
      S_WINC: state_nxt = S_IDLE;
      S_OCC:  state_nxt = alu_neg ? S_WRAP : S_CMP;
      S_WRAP: state_nxt = S_CMP;
      S_CMP:  state_nxt = alu_neg ? S_RD : S_FREE;
      S_FREE: state_nxt = S_RD;
      S_RD:   state_nxt = S_LOAD;
      S_LOAD: begin
        if (load_ok) begin
          state_nxt = (rem_r == COUNT_W'(1)) ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    size_nxt      = size_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    diff_nxt      = diff_r;
    free_nxt      = free_r;
    under_nxt     = under_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    alu_op        = ALU_ADD;
    alu_a         = '0;
    alu_b         = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (cfg_fire) begin
      if (cfg_val < CFG_W'(2)) begin
        size_nxt = SW'(2);
      end else if (32'(cfg_val) > DEPTH) begin
        size_nxt = SW'(DEPTH);
      end else begin
        size_nxt = SW'(cfg_val);
      end
      wp_nxt = '0;
      rp_nxt = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_item.op)
            OP_WRITE: ram_we = 1'b1;
            OP_READ: begin
              cnt_nxt  = cnt_clamp;
              rem_nxt  = cnt_clamp;
              addr_nxt = rp_r;
            end
            OP_FLUSH: begin
              wp_nxt = '0;
              rp_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WINC: begin
        alu_a  = AW'(wp_r);
        alu_b  = AW'(1);
        wp_nxt = (alu_sum == AW'(size_r)) ? '0 : PW'(alu_sum);
      end
      S_OCC: begin
        alu_op   = ALU_SUB;
        alu_a    = AW'(wp_r);
        alu_b    = AW'(rp_r);
        diff_nxt = DW'(alu_sum);
      end
      S_WRAP: begin
        alu_a    = AW'(diff_r);
        alu_b    = AW'(size_r);
        diff_nxt = DW'(alu_sum);
      end
      S_CMP: begin
        alu_op    = ALU_SUB;
        alu_a     = AW'(diff_r);
        alu_b     = AW'(cnt_r);
        diff_nxt  = DW'(alu_sum);
        under_nxt = alu_neg;
        if (alu_neg) begin
          free_nxt = size_r;
        end
      end
      S_FREE: begin
        alu_op   = ALU_SUB;
        alu_a    = AW'(size_r);
        alu_b    = AW'(diff_r);
        free_nxt = SW'(alu_sum);
      end
      S_RD: begin
        ram_re   = !under_r;
        alu_a    = AW'(addr_r);
        alu_b    = AW'(1);
        addr_nxt = (alu_sum == AW'(size_r)) ? '0 : PW'(alu_sum);
      end
      S_LOAD: begin
        if (load_ok) begin
          out_valid_nxt      = 1'b1;
          out_nxt.data_out   = under_r ? '0 : ram_rdata;
          out_nxt.underflow  = under_r;
          out_nxt.delivered  = under_r ? '0 : cnt_r;
          out_nxt.free_space = FREE_W'(free_r);
          out_nxt.last       = (rem_r == COUNT_W'(1));
          rem_nxt            = rem_r - COUNT_W'(1);
          if (rem_r == COUNT_W'(1)) begin
            rp_nxt = under_r ? wp_r : addr_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      size_r      <= SW'(RST_SIZE);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    addr_r  <= addr_nxt;
    diff_r  <= diff_nxt;
    free_r  <= free_nxt;
    under_r <= under_nxt;
    out_r   <= out_nxt;
  end
endmodule

// ===== sv/arb_checker.sv =====
// ----------------------------------------------------------------------------
// arb_checker: port-level checks of the audio ring buffer
// Watches in_ch.ready and out_ch over time and is bound to the top level.
// ----------------------------------------------------------------------------
module arb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input arb_pkg::out_item_t out_item
);
  import arb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Result item changed or dropped while stalled.");

  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> !in_ready)
    else $error("Input accepted in the middle of a burst.");

  a_under_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.underflow |->
      out_item.data_out == '0 && out_item.delivered == '0)
    else $error("Underflow item carries data.");

  a_deliv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.underflow |-> out_item.delivered != '0)
    else $error("Delivered count is zero without underflow.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");
endmodule

bind audio_ring_buffer_unit arb_checker u_arb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.data)
);
